// ----- hw/rtl/tsp_pkg.sv -----
// shared types and header constants for the tcp syn probe header generator
package tsp_pkg;

	localparam int unsigned PKT_WORDS = 10;
	localparam logic [3:0]  LAST_IDX  = 4'(PKT_WORDS - 1);

	localparam logic [31:0] IP_WORD0   = 32'h4500_0028;
	localparam logic [31:0] IP_WORD1   = 32'hD431_0000;
	localparam logic [15:0] IP_TTLPROT = 16'h4006;
	localparam logic [15:0] TCP_SPORT  = 16'h3039;
	localparam logic [15:0] TCP_OFFFLG = 16'h5002;
	localparam logic [15:0] TCP_WINDOW = 16'h16D0;
	localparam logic [15:0] TCP_LEN    = 16'd20;
	localparam logic [15:0] PROTO_TCP  = 16'd6;

	// fixed parts of the two ones'-complement sums
	localparam logic [18:0] IP_SUM_CONST = 19'(IP_WORD0[31:16]) + 19'(IP_WORD0[15:0])
		+ 19'(IP_WORD1[31:16]) + 19'(IP_WORD1[15:0]) + 19'(IP_TTLPROT);
	localparam logic [18:0] TCP_SUM_CONST = 19'(PROTO_TCP) + 19'(TCP_LEN)
		+ 19'(TCP_SPORT) + 19'(TCP_OFFFLG) + 19'(TCP_WINDOW);

	typedef struct packed {
		logic [31:0] dest_address;
		logic [15:0] dest_port;
	} probe_req_t;

	typedef struct packed {
		logic [31:0] packet_word;
		logic [3:0]  word_index;
		logic        last_word;
	} pkt_word_t;

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] port;
		logic [15:0] ip_csum;
		logic [15:0] tcp_csum;
	} csum_item_t;

endpackage

// ----- hw/rtl/tsp_csum_pipe.sv -----
// three-stage checksum pipeline: address sum, full sums, fold and complement
module tsp_csum_pipe import tsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [31:0] src_addr,
	input  logic       in_valid,
	output logic       in_ready,
	input  probe_req_t in_req,
	output logic       out_valid,
	input  logic       out_ready,
	output csum_item_t out_item
);

	logic        v_s1, v_s2, v_s3;
	logic        rdy1, rdy2, rdy3;
	logic [31:0] src_s1, dst_s1, src_s2, dst_s2, src_s3, dst_s3;
	logic [15:0] port_s1, port_s2, port_s3;
	logic [17:0] addr_sum_s1;
	logic [18:0] ip_acc_s2, tcp_acc_s2;
	logic [15:0] ip_ck_s3, tcp_ck_s3;
	logic [17:0] addr_sum;
	logic [16:0] ip_f1, tcp_f1;
	logic [15:0] ip_f2, tcp_f2;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign addr_sum = 18'(src_addr[31:16]) + 18'(src_addr[15:0])
		+ 18'(in_req.dest_address[31:16]) + 18'(in_req.dest_address[15:0]);

	// end-around carry folds
	assign ip_f1  = 17'(ip_acc_s2[18:16]) + 17'(ip_acc_s2[15:0]);
	assign tcp_f1 = 17'(tcp_acc_s2[18:16]) + 17'(tcp_acc_s2[15:0]);
	assign ip_f2  = 16'(16'(ip_f1[16]) + ip_f1[15:0]);
	assign tcp_f2 = 16'(16'(tcp_f1[16]) + tcp_f1[15:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			src_s1      <= src_addr;
			dst_s1      <= in_req.dest_address;
			port_s1     <= in_req.dest_port;
			addr_sum_s1 <= addr_sum;
		end
		if (rdy2 && v_s1) begin
			src_s2     <= src_s1;
			dst_s2     <= dst_s1;
			port_s2    <= port_s1;
			ip_acc_s2  <= 19'(addr_sum_s1) + IP_SUM_CONST;
			tcp_acc_s2 <= 19'(addr_sum_s1) + TCP_SUM_CONST + 19'(port_s1);
		end
		if (rdy3 && v_s2) begin
			src_s3    <= src_s2;
			dst_s3    <= dst_s2;
			port_s3   <= port_s2;
			ip_ck_s3  <= ~ip_f2;
			tcp_ck_s3 <= ~tcp_f2;
		end
	end

	assign out_valid         = v_s3;
	assign out_item.src      = src_s3;
	assign out_item.dst      = dst_s3;
	assign out_item.port     = port_s3;
	assign out_item.ip_csum  = ip_ck_s3;
	assign out_item.tcp_csum = tcp_ck_s3;

endmodule

// ----- hw/rtl/tsp_serializer.sv -----
// holds one finished header and sends it out one word per cycle while word_stall is low
module tsp_serializer import tsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  csum_item_t in_item,
	output logic       word_valid,
	input  logic       word_stall,
	output pkt_word_t  word_data
);

	logic        valid_q;
	logic [3:0]  idx_q;
	csum_item_t  item_q;
	logic        sent;
	logic        done;
	logic [31:0] words [PKT_WORDS];

	assign sent     = valid_q && !word_stall;
	assign done     = sent && (idx_q == LAST_IDX);
	assign in_ready = !valid_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (in_ready) begin
				valid_q <= in_valid;
				idx_q   <= '0;
			end else if (sent) begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_q <= in_item;
	end

	always_comb begin
		words[0] = IP_WORD0;
		words[1] = IP_WORD1;
		words[2] = {IP_TTLPROT, item_q.ip_csum};
		words[3] = item_q.src;
		words[4] = item_q.dst;
		words[5] = {TCP_SPORT, item_q.port};
		words[6] = '0;
		words[7] = '0;
		words[8] = {TCP_OFFFLG, TCP_WINDOW};
		words[9] = {item_q.tcp_csum, 16'h0000};
	end

	assign word_valid            = valid_q;
	assign word_data.packet_word = words[idx_q];
	assign word_data.word_index  = idx_q;
	assign word_data.last_word   = (idx_q == LAST_IDX);

endmodule

// ----- hw/rtl/tcp_syn_probe_header_generator.sv -----
// top level: ipv4 + tcp syn probe packet generator
//
//  channel | signals                       | moves
//  --------+-------------------------------+---------------------------------
//  req     | req_valid, req_stall, req_data| one probe request (address, port)
//  word    | word_valid, word_stall, word_data | one packet word, ten per request
//  cfg     | cfg_we, cfg_wdata             | source address write
//
// each request gives ten words at the output, one word per cycle while word_stall is low;
// the serializer holds one finished header at a time.
// a request passes the three checksum stages and the serializer register before its
// first word is offered; the stages take requests while the serializer is busy, up to three.
// arst_n clears all valid bits and sets the source address to zero.
// stall on the word channel holds the current word and backs up the pipeline.
module tcp_syn_probe_header_generator import tsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        req_valid,
	output logic        req_stall,
	input  probe_req_t  req_data,
	output logic        word_valid,
	input  logic        word_stall,
	output pkt_word_t   word_data
);

	logic [31:0] src_addr_q;
	logic        pipe_ready;
	logic        mid_valid;
	logic        mid_ready;
	csum_item_t  mid_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_addr_q <= '0;
		end else if (cfg_we) begin
			src_addr_q <= cfg_wdata;
		end
	end

	assign req_stall = !pipe_ready;

	tsp_csum_pipe u_csum (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_addr  (src_addr_q),
		.in_valid  (req_valid),
		.in_ready  (pipe_ready),
		.in_req    (req_data),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_item  (mid_item)
	);

	tsp_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (mid_valid),
		.in_ready   (mid_ready),
		.in_item    (mid_item),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word_data  (word_data)
	);

endmodule

// ----- test/tcp_syn_probe_header_generator_test.sv -----
// testbench for the tcp syn probe header generator: directed and random probe requests against a packet predictor
module tcp_syn_probe_header_generator_test;
	import tsp_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int END_CYCLES  = 20;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	probe_req_t req_data = '0;
	logic       word_valid;
	logic       word_stall = 1'b0;
	pkt_word_t  word_data;

	probe_req_t  pending_probes[$];
	pkt_word_t   expected_words[$];
	pkt_word_t   want;
	logic [31:0] source_copy = '0;
	int          mismatch_count = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	int          hold_requests = 0;
	int          hold_served = 0;
	int          quiet_cycles;
	bit          quiet_mode = 1'b0;

	tcp_syn_probe_header_generator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word_data  (word_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [15:0] ones_fold(input logic [31:0] acc);
		acc = 32'(acc[31:16]) + 32'(acc[15:0]);
		acc = 32'(acc[31:16]) + 32'(acc[15:0]);
		return acc[15:0];
	endfunction

	// folded sum over the ip header with the checksum field at zero
	function automatic logic [15:0] ip_header_sum(input logic [31:0] src, input logic [31:0] dst);
		return ones_fold(32'(IP_WORD0[31:16]) + 32'(IP_WORD0[15:0]) + 32'(IP_WORD1[31:16])
			+ 32'(IP_WORD1[15:0]) + 32'(IP_TTLPROT) + 32'(src[31:16]) + 32'(src[15:0])
			+ 32'(dst[31:16]) + 32'(dst[15:0]));
	endfunction

	// folded sum over pseudo-header and tcp header
	function automatic logic [15:0] tcp_segment_sum(input logic [31:0] src,
		input logic [31:0] dst, input logic [15:0] port);
		return ones_fold(32'(src[31:16]) + 32'(src[15:0]) + 32'(dst[31:16]) + 32'(dst[15:0])
			+ 32'(PROTO_TCP) + 32'(TCP_LEN) + 32'(TCP_SPORT) + 32'(port)
			+ 32'(TCP_OFFFLG) + 32'(TCP_WINDOW));
	endfunction

	task automatic predict_probe_packet(input probe_req_t r);
		logic [31:0] words[PKT_WORDS];
		pkt_word_t   w;
		words[0] = IP_WORD0;
		words[1] = IP_WORD1;
		words[2] = {IP_TTLPROT, ~ip_header_sum(source_copy, r.dest_address)};
		words[3] = source_copy;
		words[4] = r.dest_address;
		words[5] = {TCP_SPORT, r.dest_port};
		words[6] = '0;
		words[7] = '0;
		words[8] = {TCP_OFFFLG, TCP_WINDOW};
		words[9] = {~tcp_segment_sum(source_copy, r.dest_address, r.dest_port), 16'h0000};
		for (int k = 0; k < PKT_WORDS; k++) begin
			w.packet_word = words[k];
			w.word_index  = 4'(k);
			w.last_word   = (4'(k) == LAST_IDX);
			expected_words.push_back(w);
		end
	endtask

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet_mode || roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] exp_value);
		$display("mismatch %s: got %h, expected %h", what, got, exp_value);
		mismatch_count++;
	endtask

	task automatic queue_probe(input logic [31:0] dst, input logic [15:0] port);
		probe_req_t r;
		r.dest_address = dst;
		r.dest_port    = port;
		pending_probes.push_back(r);
	endtask

	// request whose ip and tcp checksums both come out as zero
	task automatic queue_zero_checksum();
		logic [31:0] dst;
		logic [15:0] port;
		dst  = {16'h0000, ~ip_header_sum(source_copy, 32'h0)};
		port = ~tcp_segment_sum(source_copy, dst, 16'h0000);
		queue_probe(dst, port);
	endtask

	task automatic queue_random(input int count);
		logic [31:0] dst;
		logic [15:0] port;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0: dst = '0;
				1: dst = '1;
				default: dst = $urandom;
			endcase
			case ($urandom_range(0, 9))
				0: port = '0;
				1: port = '1;
				default: port = 16'($urandom_range(0, 65535));
			endcase
			queue_probe(dst, port);
		end
	endtask

	task automatic drain_all();
		while (pending_probes.size() != 0 || req_valid || expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_source(input logic [31:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we      <= 1'b0;
		source_copy = value;
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				predict_probe_packet(req_data);
			if (!req_valid || !req_stall) begin
				if (gap_left > 0 || pending_probes.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					req_valid <= 1'b0;
				end else begin
					req_valid <= 1'b1;
					req_data  <= pending_probes.pop_front();
					gap_left  = pick_gap();
				end
			end
		end
	end

	// word monitor and receiver stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (word_valid && !word_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch("word with no request", word_data.packet_word, 32'h0);
				end else begin
					want = expected_words.pop_front();
					if (word_data.packet_word !== want.packet_word)
						report_mismatch("packet_word", word_data.packet_word, want.packet_word);
					if (word_data.word_index !== want.word_index)
						report_mismatch("word_index", 32'(word_data.word_index),
							32'(want.word_index));
					if (word_data.last_word !== want.last_word)
						report_mismatch("last_word", 32'(word_data.last_word),
							32'(want.last_word));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				word_stall <= 1'b1;
			end else if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
				word_stall  <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				word_stall <= 1'b1;
			end else begin
				stall_left = pick_gap();
				word_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no handshake
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (word_valid && !word_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed extremes
		write_source(32'hC0A8_0001);
		queue_probe(32'h0000_0000, 16'h0000);
		queue_probe(32'hFFFF_FFFF, 16'hFFFF);
		queue_probe(32'hAAAA_AAAA, 16'h5555);
		queue_probe(32'h5555_5555, 16'hAAAA);
		queue_probe(32'h0A00_0001, 16'd80);
		queue_probe(32'h8000_0000, 16'h0001);
		queue_probe(32'h0000_0001, 16'h8000);
		queue_zero_checksum();
		drain_all();

		write_source(32'hFFFF_FFFF);
		queue_probe(32'h0000_0000, 16'h0000);
		queue_probe(32'hFFFF_FFFF, 16'hFFFF);
		queue_zero_checksum();
		queue_random(90);
		drain_all();

		// back to back, no idling
		write_source(32'h0000_0000);
		quiet_mode = 1'b1;
		queue_probe(32'h0000_0000, 16'h0000);
		queue_zero_checksum();
		queue_random(90);
		drain_all();
		quiet_mode = 1'b0;

		// long receiver hold-off while requests keep coming
		write_source($urandom);
		hold_requests++;
		queue_random(90);
		drain_all();

		write_source(32'h0A00_0001);
		queue_random(90);
		drain_all();

		write_source($urandom);
		queue_random(90);
		drain_all();

		repeat (END_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_words.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_csum_pipe.sv
hw/rtl/tsp_serializer.sv
hw/rtl/tcp_syn_probe_header_generator.sv
test/tcp_syn_probe_header_generator_test.sv
